// ----- rtl/svf_pkg.sv -----
// ----------------------------------------------------------------------------
// svf_pkg: shared definitions for the state-variable filter mixer
// Widths, register indexes, reset values and the sequencer control word.
// ----------------------------------------------------------------------------
package svf_pkg;

	// Sample width default and fixed field widths.
	localparam int SAMPLE_BITS_DEF = 16;
	localparam int MOD_W = 16;
	localparam int REG_W = 20;
	localparam int MODE_W = 2;
	localparam int IDX_W = 3;

	// Internal arithmetic widths.
	localparam int COEF_W = 21;
	localparam int DRY_W = 22;
	localparam int G_W = 26;
	localparam int A_W = 33;
	localparam int B_W = 26;
	localparam int P_W = A_W + B_W;
	localparam int ACC_W = 64;
	localparam int ST_W = 48;
	localparam int WET_W = ST_W + 1;
	localparam int FRAC = 16;
	localparam int MOD_FRAC = 15;
	localparam int Y_W = ACC_W - FRAC;

	// Configuration register indexes.
	typedef enum logic [IDX_W-1:0] {
		REG_EFF_B = 3'd0,
		REG_EFF_D = 3'd1,
		REG_CUT_B = 3'd2,
		REG_CUT_D = 3'd3,
		REG_RES_B = 3'd4,
		REG_RES_D = 3'd5,
		REG_GAIN  = 3'd6,
		REG_MODE  = 3'd7
	} reg_idx_t;

	// Wet tap selection.
	typedef enum logic [MODE_W-1:0] {
		MODE_LOW  = 2'd0,
		MODE_HIGH = 2'd1,
		MODE_BAND = 2'd2,
		MODE_STOP = 2'd3
	} mode_t;

	// Register reset values.
	localparam logic signed [REG_W-1:0] EFF_B_RST = 20'sd65536;
	localparam logic signed [REG_W-1:0] EFF_D_RST = 20'sd0;
	localparam logic signed [REG_W-1:0] CUT_B_RST = 20'sd6554;
	localparam logic signed [REG_W-1:0] CUT_D_RST = 20'sd0;
	localparam logic signed [REG_W-1:0] RES_B_RST = 20'sd65536;
	localparam logic signed [REG_W-1:0] RES_D_RST = 20'sd0;
	localparam logic signed [REG_W-1:0] GAIN_RST  = 20'sd65536;

	// Multiplier operand A sources.
	typedef enum logic [3:0] {
		A_ZERO    = 4'd0,
		A_DEFF    = 4'd1,
		A_DCUT    = 4'd2,
		A_DRES    = 4'd3,
		A_EFF     = 4'd4,
		A_DRY     = 4'd5,
		A_BAND_HI = 4'd6,
		A_BAND_LO = 4'd7,
		A_HIGH_HI = 4'd8,
		A_HIGH_LO = 4'd9,
		A_WET_HI  = 4'd10,
		A_WET_LO  = 4'd11,
		A_X       = 4'd12
	} a_sel_t;

	// Multiplier operand B sources.
	typedef enum logic [2:0] {
		B_MEFF = 3'd0,
		B_MCUT = 3'd1,
		B_MRES = 3'd2,
		B_GAIN = 3'd3,
		B_RES  = 3'd4,
		B_FRQ  = 3'd5,
		B_EFFG = 3'd6,
		B_DRYG = 3'd7
	} b_sel_t;

	// Accumulator starting values.
	typedef enum logic [2:0] {
		I_ZERO  = 3'd0,
		I_EFFB  = 3'd1,
		I_CUTB  = 3'd2,
		I_RESB  = 3'd3,
		I_HINIT = 3'd4,
		I_BAND  = 3'd5,
		I_LOW   = 3'd6
	} init_sel_t;

	// Product scaling into the accumulator.
	typedef enum logic [1:0] {
		SH_0  = 2'd0,
		SH_15 = 2'd1,
		SH_16 = 2'd2
	} shift_t;

	// Destination of the accumulator sum.
	typedef enum logic [3:0] {
		D_NONE = 4'd0,
		D_EFF  = 4'd1,
		D_FRQ  = 4'd2,
		D_RES  = 4'd3,
		D_EFFG = 4'd4,
		D_DRYG = 4'd5,
		D_HIGH = 4'd6,
		D_BAND = 4'd7,
		D_LOW  = 4'd8,
		D_OUT  = 4'd9
	} dst_t;

	// Control word from the sequencer to the datapath.
	typedef struct packed {
		logic      en;
		a_sel_t    a_sel;
		b_sel_t    b_sel;
		logic      acc_en;
		logic      load;
		init_sel_t init;
		logic      sub;
		shift_t    sh;
		dst_t      dst;
	} svf_ctrl_t;

endpackage

// ----- rtl/svf_mac.sv -----
// ----------------------------------------------------------------------------
// svf_mac: shared multiply-accumulate unit
// One registered signed multiplier and one accumulator with scaled add/sub.
// ----------------------------------------------------------------------------
module svf_mac import svf_pkg::*; (
	input  logic                    clk,
	input  svf_ctrl_t               ctrl,
	input  logic signed [A_W-1:0]   a,
	input  logic signed [B_W-1:0]   b,
	input  logic signed [ACC_W-1:0] init,
	output logic signed [ACC_W-1:0] acc_sum
);

	logic signed [P_W-1:0]   prod_d;
	logic signed [P_W-1:0]   prod_q;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [ACC_W-1:0] addend;
	logic signed [ACC_W-1:0] base;

	// The product is registered before it reaches the adder.
	assign prod_d = a * b;

	// Scale the product, then add it to or subtract it from the base.
	always_comb begin
		unique case (ctrl.sh)
			SH_0:    addend = ACC_W'(prod_q);
			SH_15:   addend = ACC_W'(prod_q >>> MOD_FRAC);
			SH_16:   addend = ACC_W'(prod_q >>> FRAC);
			default: addend = '0;
		endcase
		base = ctrl.load ? init : acc_q;
		acc_sum = ctrl.sub ? (base - addend) : (base + addend);
	end

	// Product and accumulator hold while the unit is stalled.
	always_ff @(posedge clk) begin
		if (ctrl.en) begin
			prod_q <= prod_d;
			if (ctrl.acc_en) begin
				acc_q <= acc_sum;
			end
		end
	end

endmodule

// ----- rtl/svf_seq.sv -----
// ----------------------------------------------------------------------------
// svf_seq: step sequencer for the state-variable filter mixer
// Walks one item through fourteen products on the shared unit.
// ----------------------------------------------------------------------------
module svf_seq import svf_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  logic      out_free,
	output svf_ctrl_t ctrl,
	output logic      idle
);

	typedef enum logic [17:0] {
		ST_IDLE   = 18'h00001,
		ST_MOD_E  = 18'h00002,
		ST_MOD_C  = 18'h00004,
		ST_MOD_R  = 18'h00008,
		ST_GAIN_E = 18'h00010,
		ST_GAIN_D = 18'h00020,
		ST_HIGH_H = 18'h00040,
		ST_HIGH_L = 18'h00080,
		ST_HIGH_W = 18'h00100,
		ST_BAND_H = 18'h00200,
		ST_BAND_L = 18'h00400,
		ST_BAND_W = 18'h00800,
		ST_LOW_H  = 18'h01000,
		ST_LOW_L  = 18'h02000,
		ST_LOW_W  = 18'h04000,
		ST_WET_H  = 18'h08000,
		ST_WET_L  = 18'h10000,
		ST_OUT    = 18'h20000
	} state_t;

	state_t state_q;
	state_t state_d;

	// Fixed chain of steps; the last one waits for a free output register.
	always_comb begin
		unique case (state_q)
			ST_IDLE:   state_d = start ? ST_MOD_E : ST_IDLE;
			ST_MOD_E:  state_d = ST_MOD_C;
			ST_MOD_C:  state_d = ST_MOD_R;
			ST_MOD_R:  state_d = ST_GAIN_E;
			ST_GAIN_E: state_d = ST_GAIN_D;
			ST_GAIN_D: state_d = ST_HIGH_H;
			ST_HIGH_H: state_d = ST_HIGH_L;
			ST_HIGH_L: state_d = ST_HIGH_W;
			ST_HIGH_W: state_d = ST_BAND_H;
			ST_BAND_H: state_d = ST_BAND_L;
			ST_BAND_L: state_d = ST_BAND_W;
			ST_BAND_W: state_d = ST_LOW_H;
			ST_LOW_H:  state_d = ST_LOW_L;
			ST_LOW_L:  state_d = ST_LOW_W;
			ST_LOW_W:  state_d = ST_WET_H;
			ST_WET_H:  state_d = ST_WET_L;
			ST_WET_L:  state_d = ST_OUT;
			ST_OUT:    state_d = out_free ? ST_IDLE : ST_OUT;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign idle = (state_q == ST_IDLE);

	// A step may issue one product and may consume the product issued in the step before.
	always_comb begin
		ctrl = '0;
		ctrl.en = (state_q != ST_IDLE);
		unique case (state_q)
			ST_MOD_E: begin
				ctrl.a_sel = A_DEFF;
				ctrl.b_sel = B_MEFF;
			end
			ST_MOD_C: begin
				ctrl.a_sel = A_DCUT;
				ctrl.b_sel = B_MCUT;
				ctrl.load  = 1'b1;
				ctrl.init  = I_EFFB;
				ctrl.sh    = SH_15;
				ctrl.dst   = D_EFF;
			end
			ST_MOD_R: begin
				ctrl.a_sel = A_DRES;
				ctrl.b_sel = B_MRES;
				ctrl.load  = 1'b1;
				ctrl.init  = I_CUTB;
				ctrl.sh    = SH_15;
				ctrl.dst   = D_FRQ;
			end
			ST_GAIN_E: begin
				ctrl.a_sel = A_EFF;
				ctrl.b_sel = B_GAIN;
				ctrl.load  = 1'b1;
				ctrl.init  = I_RESB;
				ctrl.sh    = SH_15;
				ctrl.dst   = D_RES;
			end
			ST_GAIN_D: begin
				ctrl.a_sel = A_DRY;
				ctrl.b_sel = B_GAIN;
				ctrl.load  = 1'b1;
				ctrl.init  = I_ZERO;
				ctrl.sh    = SH_16;
				ctrl.dst   = D_EFFG;
			end
			ST_HIGH_H: begin
				ctrl.a_sel = A_BAND_HI;
				ctrl.b_sel = B_RES;
				ctrl.load  = 1'b1;
				ctrl.init  = I_ZERO;
				ctrl.sh    = SH_16;
				ctrl.dst   = D_DRYG;
			end
			ST_HIGH_L: begin
				ctrl.a_sel  = A_BAND_LO;
				ctrl.b_sel  = B_RES;
				ctrl.acc_en = 1'b1;
				ctrl.load   = 1'b1;
				ctrl.init   = I_HINIT;
				ctrl.sub    = 1'b1;
				ctrl.sh     = SH_0;
			end
			ST_HIGH_W: begin
				ctrl.sub = 1'b1;
				ctrl.sh  = SH_16;
				ctrl.dst = D_HIGH;
			end
			ST_BAND_H: begin
				ctrl.a_sel = A_HIGH_HI;
				ctrl.b_sel = B_FRQ;
			end
			ST_BAND_L: begin
				ctrl.a_sel  = A_HIGH_LO;
				ctrl.b_sel  = B_FRQ;
				ctrl.acc_en = 1'b1;
				ctrl.load   = 1'b1;
				ctrl.init   = I_BAND;
				ctrl.sh     = SH_0;
			end
			ST_BAND_W: begin
				ctrl.sh  = SH_16;
				ctrl.dst = D_BAND;
			end
			ST_LOW_H: begin
				ctrl.a_sel = A_BAND_HI;
				ctrl.b_sel = B_FRQ;
			end
			ST_LOW_L: begin
				ctrl.a_sel  = A_BAND_LO;
				ctrl.b_sel  = B_FRQ;
				ctrl.acc_en = 1'b1;
				ctrl.load   = 1'b1;
				ctrl.init   = I_LOW;
				ctrl.sh     = SH_0;
			end
			ST_LOW_W: begin
				ctrl.a_sel = A_X;
				ctrl.b_sel = B_DRYG;
				ctrl.sh    = SH_16;
				ctrl.dst   = D_LOW;
			end
			ST_WET_H: begin
				ctrl.a_sel  = A_WET_HI;
				ctrl.b_sel  = B_EFFG;
				ctrl.acc_en = 1'b1;
				ctrl.load   = 1'b1;
				ctrl.init   = I_ZERO;
				ctrl.sh     = SH_0;
			end
			ST_WET_L: begin
				ctrl.a_sel  = A_WET_LO;
				ctrl.b_sel  = B_EFFG;
				ctrl.acc_en = 1'b1;
				ctrl.sh     = SH_0;
			end
			ST_OUT: begin
				ctrl.en  = out_free;
				ctrl.sh  = SH_16;
				ctrl.dst = D_OUT;
			end
			default: begin
				ctrl.en = 1'b0;
			end
		endcase
	end

endmodule

// ----- rtl/state_variable_filter_mix.sv -----
// ----------------------------------------------------------------------------
// state_variable_filter_mix: Chamberlin state-variable filter with wet/dry mix
// Modulated coefficients, filter update and gain mix on one shared MAC.
// ----------------------------------------------------------------------------
// The block takes one item at a time: it accepts a new item only when the
// sequencer is back in idle, after the result of the last item has gone into
// the output register. A single 33x26 multiplier and one accumulator compute
// the fourteen products of an item in turn. The output register holds a
// finished result while the next item is accepted; if it is still full when
// the following result is ready, the block waits.
// ----------------------------------------------------------------------------
module state_variable_filter_mix import svf_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	localparam int IN_W = ((SAMPLE_BITS + 3 * MOD_W + 7) / 8) * 8,
	localparam int OUT_W = ((SAMPLE_BITS + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [REG_W-1:0] cfg_data,
	input  logic             s_tvalid,
	output logic             s_tready,
	// sample_in, mod_effect, mod_cutoff, mod_resonance, zero padding
	input  logic [IN_W-1:0]  s_tdata,
	// first
	input  logic             s_tuser,
	output logic             m_tvalid,
	input  logic             m_tready,
	// sample_out, zero padding
	output logic [OUT_W-1:0] m_tdata,
	// clipped
	output logic             m_tuser
);

	localparam logic signed [DRY_W-1:0] ONE_DRY = DRY_W'(1 << FRAC);
	localparam logic signed [Y_W-1:0] YMAX = Y_W'((longint'(1) <<< (SAMPLE_BITS - 1)) - 1);
	localparam logic signed [Y_W-1:0] YMIN = ~YMAX;

	// Configuration registers.
	logic signed [REG_W-1:0] eff_b_q, eff_d_q, cut_b_q, cut_d_q;
	logic signed [REG_W-1:0] res_b_q, res_d_q, gain_q;
	mode_t                   mode_q;

	// Item and coefficient registers.
	logic signed [SAMPLE_BITS-1:0] x_q;
	logic signed [MOD_W-1:0]       meff_q, mcut_q, mres_q;
	logic signed [ACC_W-1:0]       hinit_q;
	logic signed [COEF_W-1:0]      eff_q, frq_q, res_q;
	logic signed [G_W-1:0]         eff_g_q, dry_g_q;

	// Filter state.
	logic signed [ST_W-1:0] low_q, band_q, high_q;

	// Output register.
	logic                   m_tvalid_q;
	logic [SAMPLE_BITS-1:0] sample_q;
	logic                   clip_q;

	logic                    accept;
	logic                    out_free;
	logic                    idle;
	svf_ctrl_t               ctrl;
	logic signed [SAMPLE_BITS-1:0] x_in;
	logic signed [DRY_W-1:0] dry;
	logic signed [WET_W-1:0] wet;
	logic signed [A_W-1:0]   mul_a;
	logic signed [B_W-1:0]   mul_b;
	logic signed [ACC_W-1:0] init;
	logic signed [ACC_W-1:0] acc_sum;
	logic signed [Y_W-1:0]   y_full;
	logic                    y_hi, y_lo;

	// Saturate a sum to the signed range of the filter state.
	function automatic logic signed [ST_W-1:0] sat_st(input logic signed [ACC_W-1:0] v);
		logic ovf;
		ovf = (v[ACC_W-1:ST_W-1] != {(ACC_W-ST_W+1){v[ACC_W-1]}});
		if (!ovf) begin
			return v[ST_W-1:0];
		end else if (v[ACC_W-1]) begin
			return {1'b1, {(ST_W-1){1'b0}}};
		end else begin
			return {1'b0, {(ST_W-1){1'b1}}};
		end
	endfunction

	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = idle;
	assign x_in     = s_tdata[SAMPLE_BITS-1:0];

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eff_b_q <= EFF_B_RST;
			eff_d_q <= EFF_D_RST;
			cut_b_q <= CUT_B_RST;
			cut_d_q <= CUT_D_RST;
			res_b_q <= RES_B_RST;
			res_d_q <= RES_D_RST;
			gain_q  <= GAIN_RST;
			mode_q  <= MODE_LOW;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_EFF_B: eff_b_q <= cfg_data;
				REG_EFF_D: eff_d_q <= cfg_data;
				REG_CUT_B: cut_b_q <= cfg_data;
				REG_CUT_D: cut_d_q <= cfg_data;
				REG_RES_B: res_b_q <= cfg_data;
				REG_RES_D: res_d_q <= cfg_data;
				REG_GAIN:  gain_q  <= cfg_data;
				REG_MODE:  mode_q  <= mode_t'(cfg_data[MODE_W-1:0]);
			endcase
		end
	end

	// Capture an item; the high-pass start value x*2^16 - low is formed here.
	always_ff @(posedge clk) begin
		if (accept) begin
			x_q     <= x_in;
			meff_q  <= s_tdata[SAMPLE_BITS+MOD_W-1:SAMPLE_BITS];
			mcut_q  <= s_tdata[SAMPLE_BITS+2*MOD_W-1:SAMPLE_BITS+MOD_W];
			mres_q  <= s_tdata[SAMPLE_BITS+3*MOD_W-1:SAMPLE_BITS+2*MOD_W];
			hinit_q <= (ACC_W'(x_in) <<< FRAC) - (s_tuser ? '0 : ACC_W'(low_q));
		end
	end

	// Sequencer and shared multiply-accumulate unit.
	svf_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (accept),
		.out_free (out_free),
		.ctrl     (ctrl),
		.idle     (idle)
	);

	svf_mac u_mac (
		.clk     (clk),
		.ctrl    (ctrl),
		.a       (mul_a),
		.b       (mul_b),
		.init    (init),
		.acc_sum (acc_sum)
	);

	// Dry amount and the selected wet tap.
	assign dry = ONE_DRY - DRY_W'(eff_q);

	always_comb begin
		case (mode_q)
			MODE_LOW:  wet = WET_W'(low_q);
			MODE_HIGH: wet = WET_W'(high_q);
			MODE_BAND: wet = WET_W'(band_q);
			MODE_STOP: wet = WET_W'(low_q) + WET_W'(high_q);
			default:   wet = WET_W'(low_q);
		endcase
	end

	// Operand A: depths, coefficients and state split into high and low parts.
	always_comb begin
		case (ctrl.a_sel)
			A_DEFF:    mul_a = A_W'(eff_d_q);
			A_DCUT:    mul_a = A_W'(cut_d_q);
			A_DRES:    mul_a = A_W'(res_d_q);
			A_EFF:     mul_a = A_W'(eff_q);
			A_DRY:     mul_a = A_W'(dry);
			A_BAND_HI: mul_a = A_W'(band_q >>> FRAC);
			A_BAND_LO: mul_a = A_W'({1'b0, band_q[FRAC-1:0]});
			A_HIGH_HI: mul_a = A_W'(high_q >>> FRAC);
			A_HIGH_LO: mul_a = A_W'({1'b0, high_q[FRAC-1:0]});
			A_WET_HI:  mul_a = A_W'(wet >>> FRAC);
			A_WET_LO:  mul_a = A_W'({1'b0, wet[FRAC-1:0]});
			A_X:       mul_a = A_W'(x_q);
			default:   mul_a = '0;
		endcase
	end

	// Operand B: modulators, gain and coefficients.
	always_comb begin
		case (ctrl.b_sel)
			B_MEFF:  mul_b = B_W'(meff_q);
			B_MCUT:  mul_b = B_W'(mcut_q);
			B_MRES:  mul_b = B_W'(mres_q);
			B_GAIN:  mul_b = B_W'(gain_q);
			B_RES:   mul_b = B_W'(res_q);
			B_FRQ:   mul_b = B_W'(frq_q);
			B_EFFG:  mul_b = B_W'(eff_g_q);
			B_DRYG:  mul_b = B_W'(dry_g_q);
			default: mul_b = '0;
		endcase
	end

	// Accumulator start value.
	always_comb begin
		case (ctrl.init)
			I_ZERO:  init = '0;
			I_EFFB:  init = ACC_W'(eff_b_q);
			I_CUTB:  init = ACC_W'(cut_b_q);
			I_RESB:  init = ACC_W'(res_b_q);
			I_HINIT: init = hinit_q;
			I_BAND:  init = ACC_W'(band_q);
			I_LOW:   init = ACC_W'(low_q);
			default: init = '0;
		endcase
	end

	// Coefficient results.
	always_ff @(posedge clk) begin
		if (ctrl.en) begin
			case (ctrl.dst)
				D_EFF:   eff_q   <= acc_sum[COEF_W-1:0];
				D_FRQ:   frq_q   <= acc_sum[COEF_W-1:0];
				D_RES:   res_q   <= acc_sum[COEF_W-1:0];
				D_EFFG:  eff_g_q <= acc_sum[G_W-1:0];
				D_DRYG:  dry_g_q <= acc_sum[G_W-1:0];
				default: ;
			endcase
		end
	end

	// Filter state: cleared by a first item, updated with saturation.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q  <= '0;
			band_q <= '0;
			high_q <= '0;
		end else if (accept && s_tuser) begin
			low_q  <= '0;
			band_q <= '0;
			high_q <= '0;
		end else if (ctrl.en) begin
			case (ctrl.dst)
				D_HIGH:  high_q <= sat_st(acc_sum);
				D_BAND:  band_q <= sat_st(acc_sum);
				D_LOW:   low_q  <= sat_st(acc_sum);
				default: ;
			endcase
		end
	end

	// Final scaling and saturation to the sample width.
	assign y_full = acc_sum[ACC_W-1:FRAC];
	assign y_hi   = (y_full > YMAX);
	assign y_lo   = (y_full < YMIN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (ctrl.en && (ctrl.dst == D_OUT)) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.en && (ctrl.dst == D_OUT)) begin
			if (y_lo) begin
				sample_q <= YMIN[SAMPLE_BITS-1:0];
			end else if (y_hi) begin
				sample_q <= YMAX[SAMPLE_BITS-1:0];
			end else begin
				sample_q <= y_full[SAMPLE_BITS-1:0];
			end
			clip_q <= y_hi || y_lo;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = OUT_W'(sample_q);
	assign m_tuser  = clip_q;

endmodule

// ----- rtl/svf_checker.sv -----
// ----------------------------------------------------------------------------
// svf_checker: port-level checks for the state-variable filter mixer
// Watches the stream handshakes and the saturation flag.
// ----------------------------------------------------------------------------
module svf_checker import svf_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	localparam int OUT_W = ((SAMPLE_BITS + 7) / 8) * 8
) (
	input logic             clk,
	input logic             arst_n,
	input logic             s_tvalid,
	input logic             s_tready,
	input logic             m_tvalid,
	input logic             m_tready,
	input logic [OUT_W-1:0] m_tdata,
	input logic             m_tuser
);

	localparam logic [SAMPLE_BITS-1:0] SMAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic [SAMPLE_BITS-1:0] SMIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	// One item at a time: no new item right after an accepted one.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input accepted while an item is in progress");

	// A result does not rise at the checked point while the sequence still runs its steps.
	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |-> ##16 !$rose(m_tvalid))
		else $error("result appeared too early after an accepted item");

	// A clipped result sits at one end of the sample range.
	a_clip_at_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |->
			((m_tdata[SAMPLE_BITS-1:0] == SMAX) || (m_tdata[SAMPLE_BITS-1:0] == SMIN)))
		else $error("clipped flag set on an unsaturated sample");

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
		else $error("stalled result changed or was dropped");

endmodule

bind state_variable_filter_mix svf_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_svf_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
